// File: hdl/assert_macros.svh
// assertion macros used by the complex magnitude unit
// no dependencies; the assertions drop out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// File: hdl/cmf_pkg.sv
// package for the complex magnitude unit: widths, stage counts, root step
// no dependencies
package cmf_pkg;

  localparam int DATA_W          = 32;
  localparam int TAG_W           = 9;
  localparam int MAG_W           = 24;
  localparam int ROOT_STEPS      = 24;
  localparam int STEPS_PER_STAGE = 2;
  localparam int ROOT_STAGES     = ROOT_STEPS / STEPS_PER_STAGE;
  // abs stage, square stage, sum stage, then the root stages
  localparam int NUM_STAGES      = ROOT_STAGES + 3;
  localparam int ROOT_SHIFT      = 8;
  localparam int FRAC_W          = 16;

  localparam int IN_TDATA_W  = ((2 * DATA_W + TAG_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((MAG_W + TAG_W + 7) / 8) * 8;
  localparam int IN_PAD_W    = IN_TDATA_W - 2 * DATA_W - TAG_W;
  localparam int OUT_PAD_W   = OUT_TDATA_W - MAG_W - TAG_W;

  localparam logic [DATA_W-1:0] TRIAL_START = 32'h4000_0000;

  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] root;
  } rt_t;

  // one restoring step; remainder and sums wrap at the data width
  function automatic rt_t root_step(rt_t s, logic [DATA_W-1:0] trial_bit);
    rt_t               o;
    logic [DATA_W-1:0] trial;
    trial = s.root + trial_bit;
    o     = s;
    if (s.rem >= trial) begin
      o.rem  = s.rem - trial;
      o.root = trial + trial_bit;
    end
    o.rem = o.rem << 1;
    return o;
  endfunction

endpackage

// File: hdl/complex_magnitude_fixed_unit.sv
// complex magnitude unit: sqrt(re^2 + im^2) of a 16.16 bin, fully pipelined
// depends on cmf_pkg and assert_macros.svh
//
// Takes one item per clock while the output is not stalled and returns its 8.16
// magnitude with the bin index echoed. One stage takes absolute values, one
// squares both parts on two 32x32 multipliers, one adds the squares, and
// twelve stages each run two steps of the 24-step restoring square root.
// Every stage has its own valid bit and advances when its successor has room,
// so a stalled output only holds back stages that are full, and bubbles are
// squeezed out while the output waits.
`include "assert_macros.svh"

module complex_magnitude_fixed_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // real_part[31:0], imag_part[63:32], bin_index[72:64], zero pad
  input  logic [cmf_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // magnitude[23:0], bin_tag[32:24], zero pad
  output logic [cmf_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import cmf_pkg::*;

  localparam int RT_BASE = 2;

  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] v_nxt;
  logic [NUM_STAGES:0]   rdy;
  logic [TAG_W-1:0]      tag_r [NUM_STAGES];

  logic signed [DATA_W-1:0] in_re;
  logic signed [DATA_W-1:0] in_im;
  logic [DATA_W-1:0]        abs_re_r;
  logic [DATA_W-1:0]        abs_im_r;
  logic [2*DATA_W-1:0]      prod_re;
  logic [2*DATA_W-1:0]      prod_im;
  logic [DATA_W-1:0]        sq_re_r;
  logic [DATA_W-1:0]        sq_im_r;
  rt_t                      rt_r   [ROOT_STAGES+1];
  rt_t                      rt_nxt [1:ROOT_STAGES];

  // ready chain: a stage takes new data when empty or when it moves on
  assign rdy[NUM_STAGES] = out_tready;
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_rdy
    assign rdy[k] = ~v_r[k] | rdy[k+1];
  end

  always_comb begin
    v_nxt = v_r;
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (rdy[k]) begin
        v_nxt[k] = (k == 0) ? in_tvalid : v_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // tag travels with the item
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      tag_r[0] <= in_tdata[2*DATA_W +: TAG_W];
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (rdy[k]) begin
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  // absolute values; the most negative value maps to itself as unsigned
  assign in_re = in_tdata[0 +: DATA_W];
  assign in_im = in_tdata[DATA_W +: DATA_W];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      abs_re_r <= in_re[DATA_W-1] ? DATA_W'(-in_re) : DATA_W'(in_re);
      abs_im_r <= in_im[DATA_W-1] ? DATA_W'(-in_im) : DATA_W'(in_im);
    end
  end

  // 16.16 squares, truncated to 32 bits
  assign prod_re = {{DATA_W{1'b0}}, abs_re_r} * {{DATA_W{1'b0}}, abs_re_r};
  assign prod_im = {{DATA_W{1'b0}}, abs_im_r} * {{DATA_W{1'b0}}, abs_im_r};

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      sq_re_r <= prod_re[FRAC_W +: DATA_W];
      sq_im_r <= prod_im[FRAC_W +: DATA_W];
    end
  end

  // wrapping sum starts the root
  always_ff @(posedge clk) begin
    if (rdy[RT_BASE]) begin
      rt_r[0].rem  <= sq_re_r + sq_im_r;
      rt_r[0].root <= '0;
    end
  end

  for (genvar r = 1; r <= ROOT_STAGES; r++) begin : g_root
    always_comb begin
      rt_nxt[r] = rt_r[r-1];
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        rt_nxt[r] = root_step(rt_nxt[r],
                              TRIAL_START >> ((r - 1) * STEPS_PER_STAGE + j));
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[RT_BASE + r]) begin
        rt_r[r] <= rt_nxt[r];
      end
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = v_r[NUM_STAGES-1];
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, tag_r[NUM_STAGES-1],
                       rt_r[ROOT_STAGES].root[ROOT_SHIFT +: MAG_W]};

  `ASSERT_CLK(a_accept_fills, clk, rst_n, (in_tvalid && in_tready |=> v_r[0]), "accepted item lost at entry")
  `ASSERT_NEVER(a_full_when_blocked, clk, rst_n, (!in_tready && !(&v_r)), "input blocked with a bubble in the pipe")
  `ASSERT_CLK(a_stall_holds, clk, rst_n, (v_r[0] && !rdy[0] |=> v_r[0] && $stable(tag_r[0])), "stalled stage changed")
  `ASSERT_NEVER(a_root_low_bits, clk, rst_n, (out_tvalid && (rt_r[ROOT_STAGES].root[ROOT_SHIFT-1:0] != '0)), "root has bits below the last trial bit")

endmodule

// File: tb/tb_top.sv
// self-checking testbench for complex_magnitude_fixed_unit: 16.16 bin magnitude
// depends on cmf_pkg and the unit; predicts each magnitude and compares in order
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cmf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 2 * NUM_STAGES + 10;

  typedef struct {
    logic [MAG_W-1:0] magnitude;
    logic [TAG_W-1:0] tag;
  } bin_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // real_part[31:0], imag_part[63:32], bin_index[72:64], zero pad
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // magnitude[23:0], bin_tag[32:24], zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;

  bin_result_t bin_expect_q[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatches = 0;
  int          items_sent = 0;
  int          results_checked = 0;
  int          cycles = 0;

  complex_magnitude_fixed_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // 16.16 square of a signed part, truncated to 32 bits
  function automatic logic [31:0] q16_square(logic [31:0] v);
    logic [63:0] mag;
    logic [63:0] prod;
    mag = v[31] ? {32'd0, 32'd0 - v} : {32'd0, v};
    prod = mag * mag;
    return prod[47:16];
  endfunction

  // restoring root with wrapping remainder, result shifted right by 8
  function automatic logic [MAG_W-1:0] q16_root(logic [31:0] x);
    logic [31:0] rem;
    logic [31:0] root;
    logic [31:0] trial_bit;
    logic [31:0] trial;
    rem = x;
    root = '0;
    trial_bit = 32'h4000_0000;
    for (int i = 0; i < ROOT_STEPS; i++) begin
      trial = root + trial_bit;
      if (rem >= trial) begin
        rem = rem - trial;
        root = trial + trial_bit;
      end
      rem = rem << 1;
      trial_bit = trial_bit >> 1;
    end
    return root[31:8];
  endfunction

  function automatic bin_result_t bin_magnitude(logic [31:0] re, logic [31:0] im,
                                                logic [TAG_W-1:0] idx);
    bin_result_t r;
    logic [31:0] sum;
    sum = q16_square(re) + q16_square(im);
    r.magnitude = q16_root(sum);
    r.tag = idx;
    return r;
  endfunction

  function automatic logic [31:0] rand_part();
    logic [31:0] v;
    int unsigned kind;
    int unsigned k;
    kind = $urandom_range(99, 0);
    k = $urandom_range(24, 1);
    if (kind < 30) begin
      v = $urandom;
    end else if (kind < 70) begin
      v = $urandom & ((32'd1 << k) - 32'd1);
      if ($urandom_range(1, 0)) v = 32'd0 - v;
    end else if (kind < 88) begin
      // around the sum and square wrap points
      v = 32'h00B0_0000 + $urandom_range(32'h0060_0000, 0);
      if ($urandom_range(1, 0)) v = 32'd0 - v;
    end else begin
      case ($urandom_range(5, 0))
        0: v = 32'h0000_0000;
        1: v = 32'h7FFF_FFFF;
        2: v = 32'h8000_0000;
        3: v = 32'hFFFF_FFFF;
        4: v = 32'h0000_0001;
        default: v = 32'h0001_0000;
      endcase
    end
    return v;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (mismatches < 10) $display("mismatch on %s: expected %h, got %h", what, want, got);
    mismatches++;
  endtask

  task automatic check_bin_result();
    bin_result_t      want;
    logic [MAG_W-1:0] got_mag;
    logic [TAG_W-1:0] got_tag;
    got_mag = out_tdata[MAG_W-1:0];
    got_tag = out_tdata[MAG_W +: TAG_W];
    results_checked++;
    if (bin_expect_q.size() == 0) begin
      note_mismatch("item with nothing pending", 32'd0, {8'd0, got_mag});
    end else begin
      want = bin_expect_q.pop_front();
      if (got_mag !== want.magnitude) begin
        note_mismatch("magnitude", 32'(want.magnitude), 32'(got_mag));
      end
      if (got_tag !== want.tag) begin
        note_mismatch("bin_tag", 32'(want.tag), 32'(got_tag));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_bin_result();
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still pending", cycles,
               bin_expect_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_bin(input logic [31:0] re, input logic [31:0] im,
                          input logic [TAG_W-1:0] idx);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{IN_PAD_W{1'b0}}, idx, im, re};
    do begin
      @(posedge clk);
    end while (!in_tready);
    bin_expect_q.push_back(bin_magnitude(re, im, idx));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (bin_expect_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_field_extremes();
    send_bin(32'h0000_0000, 32'h0000_0000, 9'd0);
    send_bin(32'h7FFF_FFFF, 32'h0000_0000, 9'd511);
    send_bin(32'h8000_0000, 32'h0000_0000, 9'd1);
    send_bin(32'h0000_0000, 32'h7FFF_FFFF, 9'd2);
    send_bin(32'h0000_0000, 32'h8000_0000, 9'd3);
    send_bin(32'h8000_0000, 32'h8000_0000, 9'd4);
    send_bin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 9'd5);
    send_bin(32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd6);
    send_bin(32'h0000_0001, 32'h0000_0001, 9'd7);
    send_bin(32'h0001_0000, 32'h0000_0000, 9'd8);
    send_bin(32'hFFFF_0000, 32'h0001_0000, 9'd9);
    send_bin(32'h0003_0000, 32'hFFFC_0000, 9'd10);
    send_bin(32'h5555_5555, 32'hAAAA_AAAA, 9'h155);
    send_bin(32'hAAAA_AAAA, 32'h5555_5555, 9'h0AA);
  endtask

  task automatic test_wrap_cases();
    // squares at or above 2^48 lose their high bits
    send_bin(32'h0100_0000, 32'h0000_0000, 9'd11);
    send_bin(32'h0123_4567, 32'hFEDC_BA98, 9'd12);
    // sum of squares wraps past 2^32
    send_bin(32'h00B6_0000, 32'h00B6_0000, 9'd13);
    send_bin(32'h00B5_0500, 32'hFF4A_FB00, 9'd14);
    // two sums close to the top of the range, which stress the remainder, then a small and a wrapped sum
    send_bin(32'h00FF_FFFF, 32'h0000_0000, 9'd15);
    send_bin(32'h00B5_04F3, 32'h00B5_04F3, 9'd16);
    send_bin(32'h0000_FFFF, 32'hFFFF_0001, 9'd17);
    send_bin(32'hFF00_0001, 32'h0000_FFFF, 9'd18);
  endtask

  task automatic test_random_bins(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_bin(rand_part(), rand_part(), TAG_W'($urandom_range(511, 0)));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_field_extremes();
    test_wrap_cases();
    wait_results_drained();
    test_random_bins(400, 0, 0);
    test_random_bins(300, 72, 0);
    wait_results_drained();
    test_random_bins(300, 0, 72);
    test_random_bins(300, 11, 11);
    wait_results_drained();

    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("sent %0d bins (extremes, wrap cases, random parts) and checked %0d results",
             items_sent, results_checked);
    $display("phases: free flow, sparse input, heavy output stalls, light mixed idling");
    if (mismatches == 0 && bin_expect_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/cmf_pkg.sv
hdl/complex_magnitude_fixed_unit.sv
tb/tb_top.sv
